// ===== hw/rtl/approach_velocity_command_unit_macros.svh =====
// Assertion macros for the approach velocity command unit.
// Included by the top level; relies on signals named clock and reset at the point of use.
`ifndef APPROACH_VELOCITY_COMMAND_UNIT_MACROS_SVH
`define APPROACH_VELOCITY_COMMAND_UNIT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define AVC_ASSERT_COMB(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// A condition that, once seen, implies another one at the next clock edge.
`define AVC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/avc_pkg.sv =====
// Shared types and constants of the approach velocity command unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package avc_pkg;

   // Field widths.
   localparam int COORD_W = 16;
   localparam int HEAD_W  = 16;
   localparam int RATE_W  = 15;
   localparam int VMAX_W  = 13;
   localparam int WMAX_W  = 14;
   localparam int VEL_W   = 14;
   localparam int ROT_W   = 15;
   localparam int DEC_W   = 12;
   localparam int CT_W    = 8;
   localparam int CSR_W   = 12;
   localparam int CSR_IDX_W = 2;

   // Internal widths.
   localparam int AX_W     = 16;
   localparam int SQR_W    = 32;
   localparam int DSQ_W    = 33;
   localparam int RU_W     = 28;
   localparam int RPROD_W  = 44;
   localparam int ROTRAD_W = 28;
   localparam int PROD_W   = 29;
   localparam int Q_MUL_W  = 59;
   localparam int Q_W      = 23;
   localparam int R_W      = 7;
   localparam int F_MUL_W  = 25;
   localparam int FRAC_W   = 10;
   localparam int TRAD_W   = 33;
   localparam int LOOK_W   = 13;
   localparam int LTP_W    = 20;
   localparam int LKM_W    = 46;

   // Square root pipeline: one result bit per stage.
   localparam int SQ_RAD_W  = 34;
   localparam int SQ_ROOT_W = 17;
   localparam int SQ_REM_W  = 19;
   localparam int SQ_STAGES = 17;

   // Divider pipeline: one quotient bit per stage.
   localparam int DV_NUM_W  = 29;
   localparam int DV_DEN_W  = 17;
   localparam int DV_QUO_W  = 13;
   localparam int DV_REM_W  = 17;
   localparam int DV_STAGES = 13;

   // Geometry thresholds.
   localparam logic [DSQ_W-1:0]  IGNORE_DIST_SQ = 33'd32400;
   localparam logic [HEAD_W-1:0] ANGLE_TENTH_LO = 16'd1043;
   localparam logic [HEAD_W-1:0] ANGLE_TENTH_HI = 16'd64493;
   localparam logic [HEAD_W-1:0] TURN_POS_LIMIT = 16'd24576;
   localparam logic [HEAD_W-1:0] TURN_NEG_LIMIT = 16'd40960;
   localparam logic [15:0]       PI_OVER_4_Q16  = 16'd51472;

   // Reciprocals for division by constants.
   localparam logic [23:0] RECIP_1000       = 24'd8589935;
   localparam int          RECIP_1000_SHIFT = 33;
   localparam logic [29:0] RECIP_125        = 30'd549755814;
   localparam int          RECIP_125_SHIFT  = 36;
   localparam logic [17:0] RECIP_125_FRAC   = 18'd134218;
   localparam int          FRAC_SHIFT       = 14;
   localparam logic [6:0]  BRAKE_DIV        = 7'd125;

   // Register reset values.
   localparam logic [DEC_W-1:0] TRANS_DEC_RESET = 12'd768;
   localparam logic [DEC_W-1:0] ROT_DEC_RESET   = 12'd1536;
   localparam logic [CT_W-1:0]  CYCLE_RESET     = 8'd33;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TRANS_DEC  = 2'd0,
      CSR_ROT_DEC    = 2'd1,
      CSR_CYCLE_TIME = 2'd2
   } csr_index_type;

   // Per-transaction data that rides along the front half of the pipeline.
   typedef struct packed {
      logic [AX_W-1:0]      ax;
      logic [AX_W-1:0]      ay;
      logic                 sx;
      logic                 sy;
      logic                 near_pos;
      logic                 ign_pos;
      logic                 brake;
      logic [VMAX_W-1:0]    vmax;
      logic [WMAX_W-1:0]    wmax;
      logic                 dir_neg;
      logic                 rot_zero;
      logic [ROTRAD_W-1:0]  rot_rad;
      logic [SQ_ROOT_W-1:0] range_mm;
   } avc_side_type;

   // Data that rides along the divider.
   typedef struct packed {
      logic             sx;
      logic             sy;
      logic             move;
      logic [ROT_W-1:0] rot_vel;
   } avc_dside_type;

endpackage

// ===== hw/rtl/avc_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on avc_pkg for widths and the side data type.
`timescale 1ns / 1ps

module avc_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          valid_i,
   input  logic [avc_pkg::SQ_RAD_W-1:0]  rad_i,
   input  avc_pkg::avc_side_type         side_i,
   output logic                          valid_o,
   output logic [avc_pkg::SQ_ROOT_W-1:0] root_o,
   output avc_pkg::avc_side_type         side_o
);
   import avc_pkg::*;

   logic                 valid_ff [SQ_STAGES];
   logic [SQ_RAD_W-1:0]  rad_ff   [SQ_STAGES];
   logic [SQ_REM_W-1:0]  rem_ff   [SQ_STAGES];
   logic [SQ_ROOT_W-1:0] root_ff  [SQ_STAGES];
   avc_side_type         side_ff  [SQ_STAGES];

   for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
      logic                 valid_prev;
      logic [SQ_RAD_W-1:0]  rad_prev;
      logic [SQ_REM_W-1:0]  rem_prev;
      logic [SQ_ROOT_W-1:0] root_prev;
      avc_side_type         side_prev;
      logic [SQ_REM_W+1:0]  rem_cat;
      logic [SQ_REM_W+1:0]  trial;
      logic                 ge;
      logic [SQ_REM_W-1:0]  rem_in;
      logic [SQ_ROOT_W-1:0] root_in;
      logic [SQ_RAD_W-1:0]  rad_in;

      // The first stage starts from the new transaction with an empty root.
      if (s == 0) begin : g_first
         assign valid_prev = valid_i;
         assign rad_prev   = rad_i;
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign side_prev  = side_i;
      end else begin : g_next
         assign valid_prev = valid_ff[s-1];
         assign rad_prev   = rad_ff[s-1];
         assign rem_prev   = rem_ff[s-1];
         assign root_prev  = root_ff[s-1];
         assign side_prev  = side_ff[s-1];
      end

      // Bring down two radicand bits and try the next root bit.
      assign rem_cat = {rem_prev, rad_prev[SQ_RAD_W-1 -: 2]};
      assign trial   = {{(SQ_REM_W-SQ_ROOT_W){1'b0}}, root_prev, 2'b01};
      assign ge      = (rem_cat >= trial);
      assign rem_in  = ge ? SQ_REM_W'(rem_cat - trial) : SQ_REM_W'(rem_cat);
      assign root_in = {root_prev[SQ_ROOT_W-2:0], ge};
      assign rad_in  = {rad_prev[SQ_RAD_W-3:0], 2'b00};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[s]  <= rad_in;
         rem_ff[s]  <= rem_in;
         root_ff[s] <= root_in;
         side_ff[s] <= side_prev;
      end
   end

   assign valid_o = valid_ff[SQ_STAGES-1];
   assign root_o  = root_ff[SQ_STAGES-1];
   assign side_o  = side_ff[SQ_STAGES-1];

endmodule

// ===== hw/rtl/avc_div.sv =====
// Pipelined two-lane restoring divider with a shared divisor, one quotient bit per stage.
// Depends on avc_pkg; quotients must be known to fit in DV_QUO_W bits.
`timescale 1ns / 1ps

module avc_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         valid_i,
   input  logic [avc_pkg::DV_NUM_W-1:0] num_x_i,
   input  logic [avc_pkg::DV_NUM_W-1:0] num_y_i,
   input  logic [avc_pkg::DV_DEN_W-1:0] den_i,
   input  avc_pkg::avc_dside_type       side_i,
   output logic                         valid_o,
   output logic [avc_pkg::DV_QUO_W-1:0] quo_x_o,
   output logic [avc_pkg::DV_QUO_W-1:0] quo_y_o,
   output avc_pkg::avc_dside_type       side_o
);
   import avc_pkg::*;

   localparam int LANES = 2;

   logic                valid_ff [DV_STAGES];
   logic [DV_DEN_W-1:0] den_ff   [DV_STAGES];
   avc_dside_type       side_ff  [DV_STAGES];
   logic [DV_REM_W-1:0] rem_ff   [DV_STAGES][LANES];
   logic [DV_QUO_W-1:0] lo_ff    [DV_STAGES][LANES];
   logic [DV_QUO_W-1:0] quo_ff   [DV_STAGES][LANES];
   logic [DV_NUM_W-1:0] num_w    [LANES];

   assign num_w[0] = num_x_i;
   assign num_w[1] = num_y_i;

   for (genvar s = 0; s < DV_STAGES; s++) begin : g_stage
      logic                valid_prev;
      logic [DV_DEN_W-1:0] den_prev;
      avc_dside_type       side_prev;

      if (s == 0) begin : g_first
         assign valid_prev = valid_i;
         assign den_prev   = den_i;
         assign side_prev  = side_i;
      end else begin : g_next
         assign valid_prev = valid_ff[s-1];
         assign den_prev   = den_ff[s-1];
         assign side_prev  = side_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         den_ff[s]  <= den_prev;
         side_ff[s] <= side_prev;
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [DV_REM_W-1:0] rem_prev;
         logic [DV_QUO_W-1:0] lo_prev;
         logic [DV_QUO_W-1:0] quo_prev;
         logic [DV_REM_W:0]   rem_cat;
         logic                ge;
         logic [DV_REM_W-1:0] rem_in;
         logic [DV_QUO_W-1:0] lo_in;
         logic [DV_QUO_W-1:0] quo_in;

         // The upper numerator bits are already below the divisor.
         if (s == 0) begin : g_first
            assign rem_prev = DV_REM_W'(num_w[l][DV_NUM_W-1:DV_QUO_W]);
            assign lo_prev  = num_w[l][DV_QUO_W-1:0];
            assign quo_prev = '0;
         end else begin : g_next
            assign rem_prev = rem_ff[s-1][l];
            assign lo_prev  = lo_ff[s-1][l];
            assign quo_prev = quo_ff[s-1][l];
         end

         // Shift in one numerator bit and subtract the divisor when it fits.
         assign rem_cat = {rem_prev, lo_prev[DV_QUO_W-1]};
         assign ge      = (rem_cat >= (DV_REM_W+1)'(den_prev));
         assign rem_in  = ge ? DV_REM_W'(rem_cat - (DV_REM_W+1)'(den_prev))
                             : DV_REM_W'(rem_cat);
         assign lo_in   = {lo_prev[DV_QUO_W-2:0], 1'b0};
         assign quo_in  = {quo_prev[DV_QUO_W-2:0], ge};

         always_ff @(posedge clock) begin
            rem_ff[s][l] <= rem_in;
            lo_ff[s][l]  <= lo_in;
            quo_ff[s][l] <= quo_in;
         end
      end
   end

   assign valid_o = valid_ff[DV_STAGES-1];
   assign quo_x_o = quo_ff[DV_STAGES-1][0];
   assign quo_y_o = quo_ff[DV_STAGES-1][1];
   assign side_o  = side_ff[DV_STAGES-1];

endmodule

// ===== hw/rtl/approach_velocity_command_unit.sv =====
// Approach velocity command unit: world-frame velocity toward a target with braking limit.
// Depends on avc_pkg, avc_isqrt, avc_div and the assertion macro header.
// Accepts one transaction per cycle.
// The depth is set by two 17-stage square roots in series and a 13-stage divider.
// busy is high only during reset; reset clears all valid bits and loads the register defaults.
// The receiver cannot stall, so results leave in the order they were accepted.
`timescale 1ns / 1ps
`include "approach_velocity_command_unit_macros.svh"

module approach_velocity_command_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [avc_pkg::COORD_W-1:0]   req_goal_x,
   input  logic signed [avc_pkg::COORD_W-1:0]   req_goal_y,
   input  logic        [avc_pkg::HEAD_W-1:0]    req_goal_heading,
   input  logic signed [avc_pkg::COORD_W-1:0]   req_robot_x,
   input  logic signed [avc_pkg::COORD_W-1:0]   req_robot_y,
   input  logic        [avc_pkg::HEAD_W-1:0]    req_robot_heading,
   input  logic signed [avc_pkg::RATE_W-1:0]    req_robot_rot_rate,
   input  logic        [avc_pkg::VMAX_W-1:0]    req_speed_limit,
   input  logic        [avc_pkg::WMAX_W-1:0]    req_turn_limit,
   input  logic                                 req_ignore_position,
   input  logic                                 req_ignore_rotation,
   input  logic                                 req_brake_at_target,
   output logic                                 rsp_valid,
   output logic signed [avc_pkg::VEL_W-1:0]     rsp_vel_x,
   output logic signed [avc_pkg::VEL_W-1:0]     rsp_vel_y,
   output logic signed [avc_pkg::ROT_W-1:0]     rsp_rot_vel,
   input  logic                                 csr_we,
   input  logic        [avc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [avc_pkg::CSR_W-1:0]     csr_wdata
);
   import avc_pkg::*;

   // Configuration registers.
   logic [DEC_W-1:0]  trans_dec_ff;
   logic [DEC_W-1:0]  rot_dec_ff;
   logic [CT_W-1:0]   cycle_ff;
   logic [LTP_W-1:0]  lt_prod_ff, lt_prod_in;
   logic [LTP_W-1:0]  lr_prod_ff, lr_prod_in;
   logic [LOOK_W-1:0] look_t_ff, look_t_in;
   logic [LOOK_W-1:0] look_r_ff, look_r_in;
   logic [LKM_W-1:0]  lt_mul, lr_mul;

   // Pipeline stage registers.
   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic              s4_valid_ff, s5_valid_ff, s6_valid_ff, s7_valid_ff;
   logic              s8_valid_ff, s9_valid_ff, s10_valid_ff;
   avc_side_type      s1_side_ff, s1_side_in;
   logic [HEAD_W-1:0] s1_u_ff, s1_u_in;
   avc_side_type      s2_side_ff;
   logic [SQR_W-1:0]  s2_axx_ff, s2_axx_in, s2_ayy_ff, s2_ayy_in;
   logic [RU_W-1:0]   s2_ru_ff, s2_ru_in;
   avc_side_type      s3_side_ff, s3_side_in;
   logic [DSQ_W-1:0]  s3_dsq_ff, s3_dsq_in;
   logic [RPROD_W-1:0] s3_rprod;
   avc_side_type      s4_side_ff, s4_side_in;
   logic [PROD_W-1:0] s4_prod_ff, s4_prod_in;
   avc_side_type      s5_side_ff;
   logic [PROD_W-1:0] s5_prod_ff;
   logic [Q_MUL_W-1:0] s5_qmul;
   logic [Q_W-1:0]    s5_q_ff, s5_q_in;
   avc_side_type      s6_side_ff;
   logic [Q_W-1:0]    s6_q_ff;
   logic [PROD_W-1:0] s6_qtimes;
   logic [R_W-1:0]    s6_r_ff, s6_r_in;
   avc_side_type      s7_side_ff;
   logic [F_MUL_W-1:0] s7_fmul;
   logic [TRAD_W-1:0] s7_trad_ff, s7_trad_in;
   avc_side_type      s8_side_ff;
   logic [SQ_ROOT_W-1:0] s8_vb_ff, s8_vb_in, s8_wb_ff, s8_wb_in;
   avc_side_type      s9_side_ff;
   logic [VMAX_W-1:0] s9_cap_ff, s9_cap_in;
   logic [ROT_W-1:0]  s9_rv_ff, s9_rv_in;
   logic              s9_move_ff, s9_move_in;
   logic [WMAX_W-1:0] s9_w;
   logic [DV_NUM_W-1:0] s10_numx_ff, s10_numx_in, s10_numy_ff, s10_numy_in;
   logic [DV_DEN_W-1:0] s10_den_ff;
   avc_dside_type     s10_dside_ff, s10_dside_in;

   // Front-end combinational helpers.
   logic [COORD_W:0]  dx_w, dy_w;
   logic [HEAD_W-1:0] d_w;

   // Square root and divider interfaces.
   logic                 p1_valid;
   logic [SQ_ROOT_W-1:0] p1_root;
   avc_side_type         p1_side;
   logic                 p2_valid;
   logic [SQ_ROOT_W-1:0] p2_troot;
   logic [SQ_ROOT_W-1:0] p2_rroot;
   avc_side_type         p2_side;
   logic                 dv_valid;
   logic [DV_QUO_W-1:0]  dv_qx, dv_qy;
   avc_dside_type        dv_side;

   // Output registers.
   logic                     rsp_valid_ff;
   logic signed [VEL_W-1:0]  vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;
   logic signed [ROT_W-1:0]  rot_ff;

   assign busy = reset;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         trans_dec_ff <= TRANS_DEC_RESET;
         rot_dec_ff   <= ROT_DEC_RESET;
         cycle_ff     <= CYCLE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TRANS_DEC:  trans_dec_ff <= csr_wdata;
            CSR_ROT_DEC:    rot_dec_ff   <= csr_wdata;
            CSR_CYCLE_TIME: cycle_ff     <= csr_wdata[CT_W-1:0];
            default: ;
         endcase
      end
   end

   // Lookahead terms a*T*4/1000, refreshed through lt_prod_ff/lr_prod_ff and then look_t_ff/look_r_ff after a write.
   always_comb begin
      lt_prod_in = LTP_W'(trans_dec_ff) * LTP_W'(cycle_ff);
      lr_prod_in = LTP_W'(rot_dec_ff) * LTP_W'(cycle_ff);
      lt_mul     = LKM_W'({lt_prod_ff, 2'b00}) * LKM_W'(RECIP_1000);
      lr_mul     = LKM_W'({lr_prod_ff, 2'b00}) * LKM_W'(RECIP_1000);
      look_t_in  = lt_mul[RECIP_1000_SHIFT +: LOOK_W];
      look_r_in  = lr_mul[RECIP_1000_SHIFT +: LOOK_W];
   end

   always_ff @(posedge clock) begin
      lt_prod_ff <= lt_prod_in;
      lr_prod_ff <= lr_prod_in;
      look_t_ff  <= look_t_in;
      look_r_ff  <= look_r_in;
   end

   // Stage 1: offsets, heading error and turn direction.
   always_comb begin
      dx_w = {req_goal_x[COORD_W-1], req_goal_x} - {req_robot_x[COORD_W-1], req_robot_x};
      dy_w = {req_goal_y[COORD_W-1], req_goal_y} - {req_robot_y[COORD_W-1], req_robot_y};
      d_w  = req_goal_heading - req_robot_heading;

      s1_side_in          = '0;
      s1_side_in.sx       = dx_w[COORD_W];
      s1_side_in.sy       = dy_w[COORD_W];
      s1_side_in.ax       = dx_w[COORD_W] ? AX_W'(~dx_w + 1'b1) : dx_w[AX_W-1:0];
      s1_side_in.ay       = dy_w[COORD_W] ? AX_W'(~dy_w + 1'b1) : dy_w[AX_W-1:0];
      s1_side_in.ign_pos  = req_ignore_position;
      s1_side_in.brake    = req_brake_at_target;
      s1_side_in.vmax     = req_speed_limit;
      s1_side_in.wmax     = req_turn_limit;
      s1_side_in.rot_zero = req_ignore_rotation &&
                            (d_w <= ANGLE_TENTH_LO || d_w >= ANGLE_TENTH_HI);
      priority if (d_w <= TURN_POS_LIMIT) begin
         s1_side_in.dir_neg = 1'b0;
      end else if (d_w >= TURN_NEG_LIMIT) begin
         s1_side_in.dir_neg = 1'b1;
      end else begin
         s1_side_in.dir_neg = req_robot_rot_rate[RATE_W-1];
      end
      // Remaining angle in the chosen direction.
      s1_u_in = s1_side_in.dir_neg ? HEAD_W'(~d_w + 1'b1) : d_w;
   end

   // Stage 2: squares and the rotational deceleration product.
   always_comb begin
      s2_axx_in = SQR_W'(s1_side_ff.ax) * SQR_W'(s1_side_ff.ax);
      s2_ayy_in = SQR_W'(s1_side_ff.ay) * SQR_W'(s1_side_ff.ay);
      s2_ru_in  = RU_W'(rot_dec_ff) * RU_W'(s1_u_ff);
   end

   // Stage 3: squared range and rotational radicand r*U*pi/4.
   always_comb begin
      s3_dsq_in           = DSQ_W'(s2_axx_ff) + DSQ_W'(s2_ayy_ff);
      s3_rprod            = RPROD_W'(s2_ru_ff) * RPROD_W'(PI_OVER_4_Q16);
      s3_side_in          = s2_side_ff;
      s3_side_in.near_pos = (s3_dsq_in < IGNORE_DIST_SQ);
      s3_side_in.rot_rad  = s3_rprod[RPROD_W-1 -: ROTRAD_W];
   end

   avc_isqrt u_range_sqrt (
      .clock   (clock),
      .reset   (reset),
      .valid_i (s3_valid_ff),
      .rad_i   (SQ_RAD_W'(s3_dsq_ff)),
      .side_i  (s3_side_ff),
      .valid_o (p1_valid),
      .root_o  (p1_root),
      .side_o  (p1_side)
   );

   // Stages 4 to 7: radicand a*D*8192/1000 split as q*1024 + frac.
   always_comb begin
      s4_prod_in          = PROD_W'(trans_dec_ff) * PROD_W'(p1_root);
      s4_side_in          = p1_side;
      s4_side_in.range_mm = p1_root;
      s5_qmul             = Q_MUL_W'(s4_prod_ff) * Q_MUL_W'(RECIP_125);
      s5_q_in             = s5_qmul[RECIP_125_SHIFT +: Q_W];
      s6_qtimes           = PROD_W'(s5_q_ff) * PROD_W'(BRAKE_DIV);
      s6_r_in             = R_W'(s5_prod_ff - s6_qtimes);
      s7_fmul             = F_MUL_W'(s6_r_ff) * F_MUL_W'(RECIP_125_FRAC);
      s7_trad_in          = {s6_q_ff, s7_fmul[FRAC_SHIFT +: FRAC_W]};
   end

   avc_isqrt u_trans_sqrt (
      .clock   (clock),
      .reset   (reset),
      .valid_i (s7_valid_ff),
      .rad_i   (SQ_RAD_W'(s7_trad_ff)),
      .side_i  (s7_side_ff),
      .valid_o (p2_valid),
      .root_o  (p2_troot),
      .side_o  (p2_side)
   );

   // The rotational root runs beside the translational one; its sideband is not needed.
   avc_isqrt u_rot_sqrt (
      .clock   (clock),
      .reset   (reset),
      .valid_i (s7_valid_ff),
      .rad_i   (SQ_RAD_W'(s7_side_ff.rot_rad)),
      .side_i  (s7_side_ff),
      .valid_o (),
      .root_o  (p2_rroot),
      .side_o  ()
   );

   // Stage 8: subtract lookahead, floor at zero.
   always_comb begin
      s8_vb_in = (p2_troot > SQ_ROOT_W'(look_t_ff)) ?
                 SQ_ROOT_W'(p2_troot - SQ_ROOT_W'(look_t_ff)) : '0;
      s8_wb_in = (p2_rroot > SQ_ROOT_W'(look_r_ff)) ?
                 SQ_ROOT_W'(p2_rroot - SQ_ROOT_W'(look_r_ff)) : '0;
   end

   // Stage 9: speed cap, rotation command and motion gate.
   always_comb begin
      s9_cap_in = (s8_side_ff.brake && s8_vb_ff < SQ_ROOT_W'(s8_side_ff.vmax)) ?
                  VMAX_W'(s8_vb_ff) : s8_side_ff.vmax;
      s9_w      = (s8_wb_ff < SQ_ROOT_W'(s8_side_ff.wmax)) ?
                  WMAX_W'(s8_wb_ff) : s8_side_ff.wmax;
      if (s8_side_ff.rot_zero) begin
         s9_rv_in = '0;
      end else if (s8_side_ff.dir_neg) begin
         s9_rv_in = ROT_W'(~{1'b0, s9_w} + 1'b1);
      end else begin
         s9_rv_in = {1'b0, s9_w};
      end
      s9_move_in = (s8_side_ff.range_mm != '0) &&
                   !(s8_side_ff.ign_pos && s8_side_ff.near_pos);
   end

   // Stage 10: numerators cap*|d| for the component divide.
   always_comb begin
      s10_numx_in          = DV_NUM_W'(s9_cap_ff) * DV_NUM_W'(s9_side_ff.ax);
      s10_numy_in          = DV_NUM_W'(s9_cap_ff) * DV_NUM_W'(s9_side_ff.ay);
      s10_dside_in.sx      = s9_side_ff.sx;
      s10_dside_in.sy      = s9_side_ff.sy;
      s10_dside_in.move    = s9_move_ff;
      s10_dside_in.rot_vel = s9_rv_ff;
   end

   // Valid bits of the local stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         s10_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= start && !busy;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= p1_valid;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= s6_valid_ff;
         s8_valid_ff  <= p2_valid;
         s9_valid_ff  <= s8_valid_ff;
         s10_valid_ff <= s9_valid_ff;
         rsp_valid_ff <= dv_valid;
      end
   end

   // Payload of the local stages.
   always_ff @(posedge clock) begin
      s1_side_ff   <= s1_side_in;
      s1_u_ff      <= s1_u_in;
      s2_side_ff   <= s1_side_ff;
      s2_axx_ff    <= s2_axx_in;
      s2_ayy_ff    <= s2_ayy_in;
      s2_ru_ff     <= s2_ru_in;
      s3_side_ff   <= s3_side_in;
      s3_dsq_ff    <= s3_dsq_in;
      s4_side_ff   <= s4_side_in;
      s4_prod_ff   <= s4_prod_in;
      s5_side_ff   <= s4_side_ff;
      s5_prod_ff   <= s4_prod_ff;
      s5_q_ff      <= s5_q_in;
      s6_side_ff   <= s5_side_ff;
      s6_q_ff      <= s5_q_ff;
      s6_r_ff      <= s6_r_in;
      s7_side_ff   <= s6_side_ff;
      s7_trad_ff   <= s7_trad_in;
      s8_side_ff   <= p2_side;
      s8_vb_ff     <= s8_vb_in;
      s8_wb_ff     <= s8_wb_in;
      s9_side_ff   <= s8_side_ff;
      s9_cap_ff    <= s9_cap_in;
      s9_rv_ff     <= s9_rv_in;
      s9_move_ff   <= s9_move_in;
      s10_numx_ff  <= s10_numx_in;
      s10_numy_ff  <= s10_numy_in;
      s10_den_ff   <= s9_side_ff.range_mm;
      s10_dside_ff <= s10_dside_in;
   end

   avc_div u_comp_div (
      .clock   (clock),
      .reset   (reset),
      .valid_i (s10_valid_ff),
      .num_x_i (s10_numx_ff),
      .num_y_i (s10_numy_ff),
      .den_i   (s10_den_ff),
      .side_i  (s10_dside_ff),
      .valid_o (dv_valid),
      .quo_x_o (dv_qx),
      .quo_y_o (dv_qy),
      .side_o  (dv_side)
   );

   // Output stage: restore signs and zero the translation when not moving.
   always_comb begin
      if (!dv_side.move) begin
         vel_x_in = '0;
         vel_y_in = '0;
      end else begin
         vel_x_in = dv_side.sx ? VEL_W'(~{1'b0, dv_qx} + 1'b1) : {1'b0, dv_qx};
         vel_y_in = dv_side.sy ? VEL_W'(~{1'b0, dv_qy} + 1'b1) : {1'b0, dv_qy};
      end
   end

   always_ff @(posedge clock) begin
      vel_x_ff <= vel_x_in;
      vel_y_ff <= vel_y_in;
      rot_ff   <= dv_side.rot_vel;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_vel_x   = vel_x_ff;
   assign rsp_vel_y   = vel_y_ff;
   assign rsp_rot_vel = rot_ff;

   // Consistency checks.
   `AVC_ASSERT_COMB(a_cap_limit, !s9_valid_ff || s9_cap_ff <= s9_side_ff.vmax, "speed cap above limit")
   `AVC_ASSERT_COMB(a_rot_sign, !s9_valid_ff || s9_side_ff.dir_neg || !s9_rv_ff[ROT_W-1], "rotation sign mismatch")
   `AVC_ASSERT_NEXT(a_still_zero, dv_valid && !dv_side.move, rsp_vel_x == '0 && rsp_vel_y == '0, "velocity not zero when gated")

endmodule
